>>> sv/bgsc_pkg.sv
`timescale 1ns / 1ps

package bgsc_pkg;

  // Field widths
  localparam int OP_W    = 3;
  localparam int BEAT_W  = 48;
  localparam int SET_W   = 8;
  localparam int TICK_W  = 7;
  localparam int MULT_W  = 8;
  localparam int UNITS_W = 40;

  // Serial datapath widths. The beat difference carries one extra sign bit.
  // One grid unit is 4 * mult beats at 16 fraction bits, so the divisor is
  // mult shifted left by 18.
  localparam int DELTA_W    = BEAT_W + 1;
  localparam int PW         = DELTA_W + TICK_W;
  localparam int FRAC_SHIFT = 18;
  localparam int QW         = PW - FRAC_SHIFT;

  localparam int CATCHUP_DEF = 8;
  localparam logic [TICK_W-1:0] DIV_MAX = TICK_W'(96);

  localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(1);
  localparam logic [TICK_W-1:0] DIV_RESET  = TICK_W'(16);

  localparam logic [OP_W-1:0] OP_START    = 3'd0;
  localparam logic [OP_W-1:0] OP_STOP     = 3'd1;
  localparam logic [OP_W-1:0] OP_BEAT     = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_MULT = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_DIV  = 3'd4;

  typedef struct packed {
    logic done;
    logic nonpos;
  } bgsc_mul_st_t;

endpackage

>>> sv/beat_grid_step_counter_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_op, in_beat_pos, in_beat_valid, in_set_value
// out_      output     out_valid/out_stall out_tick, out_last
// cfg_      input      cfg_valid/cfg_ready cfg_data (clock bound)
//
// Start, stop and sets outside a run use no serial unit; a start with the clock bound then delivers one item.
// A set while running with the clock bound wraps the count through the serial remainder unit.
// A beat update that advances passes through bit-serial subtract and multiply,
// restoring division, a prep step and the serial remainder unit before its first item.
// Reset is synchronous and active low; no clearing pass is needed.
// The output register lets a waiting result sit while the next item is accepted.
module beat_grid_step_counter_unit #(
  parameter int CATCHUP = bgsc_pkg::CATCHUP_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bgsc_pkg::OP_W-1:0]    in_op,
  input  logic signed [bgsc_pkg::BEAT_W-1:0] in_beat_pos,
  input  logic                         in_beat_valid,
  input  logic [bgsc_pkg::SET_W-1:0]   in_set_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bgsc_pkg::TICK_W-1:0]  out_tick,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_data
);
  import bgsc_pkg::*;

  localparam int CW = $clog2(CATCHUP + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_MOD  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic               clock_bound_r, clock_bound_nxt;
  logic               running_r, running_nxt;
  logic               base_valid_r, base_valid_nxt;
  logic [MULT_W-1:0]  mult_r, mult_nxt;
  logic [TICK_W-1:0]  div_r, div_nxt;
  logic [TICK_W-1:0]  step_count_r, step_count_nxt;
  logic [UNITS_W-1:0] units_done_r, units_done_nxt;
  logic               mod_for_set_r, mod_for_set_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [BEAT_W-1:0]  grid_base_r, grid_base_nxt;
  logic [UNITS_W-1:0] advance_r, advance_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [CW-1:0]      remain_r, remain_nxt;
  logic [TICK_W-1:0]  out_tick_r, out_tick_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               cfg_accept;
  logic               out_load;
  logic [MULT_W-1:0]  new_mult;
  logic [TICK_W-1:0]  new_div;
  logic [TICK_W-1:0]  div_set;
  logic               mul_start;
  logic               div_start;
  logic               mod_start;
  logic [UNITS_W-1:0] mod_val;
  logic [TICK_W-1:0]  mod_div;
  bgsc_mul_st_t       mul_st;
  logic [QW-1:0]      mul_num;
  logic               div_done;
  logic [UNITS_W-1:0] div_quot;
  logic               mod_done;
  logic [TICK_W-1:0]  mod_rem;
  logic [UNITS_W:0]   units_diff;
  logic               prep_big;
  logic [UNITS_W-1:0] prep_n;
  logic [TICK_W:0]    tick_p1;

  bgsc_smul u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .beat  (in_beat_pos),
    .base  (grid_base_r),
    .div   (div_r),
    .st    (mul_st),
    .num   (mul_num)
  );

  bgsc_sdiv u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_num),
    .mult  (mult_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  bgsc_smod u_smod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .val   (mod_val),
    .div   (mod_div),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    accept     = in_valid && (state_r == S_IDLE);
    cfg_accept = cfg_valid && (state_r == S_IDLE);
    out_load   = !out_valid_r || !out_stall;

    new_mult = (in_set_value == '0) ? MULT_W'(1) : in_set_value;
    if (in_set_value == '0) begin
      new_div = TICK_W'(1);
    end else if (in_set_value > {1'b0, DIV_MAX}) begin
      new_div = DIV_MAX;
    end else begin
      new_div = TICK_W'(in_set_value);
    end
    div_set = (in_op == OP_SET_DIV) ? new_div : div_r;

    units_diff = {1'b0, div_quot} - {1'b0, units_done_r};
    prep_big   = advance_r > UNITS_W'(CATCHUP);
    prep_n     = prep_big ? (advance_r - UNITS_W'(CATCHUP - 1)) : UNITS_W'(1);
    tick_p1    = {1'b0, tick_r} + 1'b1;

    // The count can lie outside the cycle when a division was stored out of a run or while
    // the clock was unbound, so it is wrapped together with the offset to the first tick.
    mod_val = (state_r == S_IDLE) ? UNITS_W'(step_count_r)
                                  : (prep_n + UNITS_W'(step_count_r));
    mod_div = (state_r == S_IDLE) ? div_set : div_r;

    state_nxt       = state_r;
    clock_bound_nxt = clock_bound_r;
    running_nxt     = running_r;
    base_valid_nxt  = base_valid_r;
    mult_nxt        = mult_r;
    div_nxt         = div_r;
    step_count_nxt  = step_count_r;
    units_done_nxt  = units_done_r;
    mod_for_set_nxt = mod_for_set_r;
    grid_base_nxt   = grid_base_r;
    advance_nxt     = advance_r;
    tick_nxt        = tick_r;
    remain_nxt      = remain_r;
    out_tick_nxt    = out_tick_r;
    out_last_nxt    = out_last_r;
    out_valid_nxt   = out_valid_r && out_stall;
    mul_start       = 1'b0;
    div_start       = 1'b0;
    mod_start       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_START: begin
              running_nxt = 1'b0;
              if (clock_bound_r) begin
                running_nxt    = 1'b1;
                units_done_nxt = '0;
                base_valid_nxt = in_beat_valid;
                if (in_beat_valid) begin
                  grid_base_nxt = in_beat_pos;
                end
                tick_nxt   = '0;
                remain_nxt = CW'(1);
                state_nxt  = S_EMIT;
              end
            end
            OP_STOP: begin
              running_nxt = 1'b0;
            end
            OP_BEAT: begin
              if (running_r && clock_bound_r && in_beat_valid) begin
                if (!base_valid_r) begin
                  // First valid beat after a start without one takes the grid here.
                  grid_base_nxt  = in_beat_pos;
                  base_valid_nxt = 1'b1;
                  units_done_nxt = '0;
                end else begin
                  mul_start = 1'b1;
                  state_nxt = S_MUL;
                end
              end
            end
            OP_SET_MULT, OP_SET_DIV: begin
              mult_nxt = (in_op == OP_SET_MULT) ? new_mult : mult_r;
              div_nxt  = div_set;
              if (running_r && clock_bound_r) begin
                // Either factor alone changes, so the ratio changes iff it differs.
                if (in_beat_valid && ((in_op == OP_SET_MULT) ? (new_mult != mult_r)
                                                             : (new_div != div_r))) begin
                  grid_base_nxt  = in_beat_pos;
                  base_valid_nxt = 1'b1;
                  units_done_nxt = '0;
                end
                mod_start       = 1'b1;
                mod_for_set_nxt = 1'b1;
                state_nxt       = S_MOD;
              end
            end
            default: begin
            end
          endcase
        end
        if (cfg_accept) begin
          clock_bound_nxt = cfg_data;
          if (cfg_data && running_r) begin
            base_valid_nxt = 1'b0;
            units_done_nxt = '0;
          end
        end
      end
      S_MUL: begin
        if (mul_st.done) begin
          if (mul_st.nonpos) begin
            state_nxt = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          // Only a clock that moved past the units already counted advances.
          if (!units_diff[UNITS_W] && (units_diff[UNITS_W-1:0] != '0)) begin
            advance_nxt    = units_diff[UNITS_W-1:0];
            units_done_nxt = div_quot;
            state_nxt      = S_PREP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PREP: begin
        remain_nxt      = prep_big ? CW'(CATCHUP) : CW'(advance_r);
        mod_start       = 1'b1;
        mod_for_set_nxt = 1'b0;
        state_nxt       = S_MOD;
      end
      S_MOD: begin
        if (mod_done) begin
          if (mod_for_set_r) begin
            step_count_nxt = mod_rem;
            state_nxt      = S_IDLE;
          end else begin
            // First emitted tick: the count moved on by all units but the emitted ones.
            tick_nxt  = mod_rem;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_tick_nxt  = tick_r;
          out_last_nxt  = (remain_r == CW'(1));
          remain_nxt    = remain_r - 1'b1;
          tick_nxt      = (tick_p1 == {1'b0, div_r}) ? '0 : TICK_W'(tick_p1);
          if (remain_r == CW'(1)) begin
            step_count_nxt = tick_r;
            state_nxt      = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      clock_bound_r <= 1'b0;
      running_r     <= 1'b0;
      base_valid_r  <= 1'b0;
      mult_r        <= MULT_RESET;
      div_r         <= DIV_RESET;
      step_count_r  <= '0;
      units_done_r  <= '0;
      mod_for_set_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clock_bound_r <= clock_bound_nxt;
      running_r     <= running_nxt;
      base_valid_r  <= base_valid_nxt;
      mult_r        <= mult_nxt;
      div_r         <= div_nxt;
      step_count_r  <= step_count_nxt;
      units_done_r  <= units_done_nxt;
      mod_for_set_r <= mod_for_set_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grid_base_r <= grid_base_nxt;
    advance_r   <= advance_nxt;
    tick_r      <= tick_nxt;
    remain_r    <= remain_nxt;
    out_tick_r  <= out_tick_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_tick  = out_tick_r;
  assign out_last  = out_last_r;

`ifndef SYNTH
  a_emit_remain: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_EMIT |-> remain_r != '0)
    else $error("emission running with no item left to send");

  a_emit_tick: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_EMIT |-> tick_r < div_r)
    else $error("tick outside the current cycle");

  a_emit_running: assert property (@(posedge clk) disable iff (!rst_n)
      state_r == S_EMIT |-> running_r)
    else $error("ticks emitted while the counter is stopped");

  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
      div_r != '0 && div_r <= DIV_MAX && mult_r != '0)
    else $error("division or multiplier out of range");
`endif

endmodule

>>> sv/bgsc_smul.sv
`timescale 1ns / 1ps

module bgsc_smul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bgsc_pkg::BEAT_W-1:0]   beat,
  input  logic [bgsc_pkg::BEAT_W-1:0]   base,
  input  logic [bgsc_pkg::TICK_W-1:0]   div,
  output bgsc_pkg::bgsc_mul_st_t        st,
  output logic [bgsc_pkg::QW-1:0]       num
);
  import bgsc_pkg::*;

  localparam int CNT_W = $clog2(DELTA_W);

  logic [BEAT_W-1:0]  a_sr_r;
  logic [BEAT_W-1:0]  b_sr_r;
  logic               borrow_r;
  logic [TICK_W-1:0]  carry_r;
  logic [DELTA_W-1:0] prod_sr_r;
  logic               nz_r;
  logic               sign_r;
  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               d_bit;
  logic               borrow_nxt;
  logic [TICK_W:0]    acc;
  logic               last_bit;
  logic [PW-1:0]      prod_full;

  // The difference is formed LSB first and each bit is multiplied by the
  // division straight away; the carry holds the pending upper product bits.
  always_comb begin
    d_bit      = a_sr_r[0] ^ b_sr_r[0] ^ borrow_r;
    borrow_nxt = (~a_sr_r[0] & b_sr_r[0]) | (~(a_sr_r[0] ^ b_sr_r[0]) & borrow_r);
    acc        = {1'b0, carry_r} + (d_bit ? {1'b0, div} : '0);
    last_bit   = busy_r && (cnt_r == CNT_W'(DELTA_W - 1));
    prod_full  = {carry_r, prod_sr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_bit;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sr_r   <= beat;
      b_sr_r   <= base;
      borrow_r <= 1'b0;
      carry_r  <= '0;
      nz_r     <= 1'b0;
    end else if (busy_r) begin
      // Arithmetic shift, so the top step sees the sign of both operands.
      a_sr_r    <= {a_sr_r[BEAT_W-1], a_sr_r[BEAT_W-1:1]};
      b_sr_r    <= {b_sr_r[BEAT_W-1], b_sr_r[BEAT_W-1:1]};
      borrow_r  <= borrow_nxt;
      carry_r   <= acc[TICK_W:1];
      prod_sr_r <= {acc[0], prod_sr_r[DELTA_W-1:1]};
      nz_r      <= nz_r | d_bit;
      sign_r    <= d_bit;
    end
  end

  assign st.done   = done_r;
  assign st.nonpos = sign_r | ~nz_r;
  assign num       = prod_full[PW-1:FRAC_SHIFT];

endmodule

>>> sv/bgsc_sdiv.sv
`timescale 1ns / 1ps

module bgsc_sdiv (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bgsc_pkg::QW-1:0]       num,
  input  logic [bgsc_pkg::MULT_W-1:0]   mult,
  output logic                          done,
  output logic [bgsc_pkg::UNITS_W-1:0]  quot
);
  import bgsc_pkg::*;

  localparam int CNT_W = $clog2(QW);

  logic [MULT_W-1:0] rem_r;
  logic [QW-1:0]     q_sr_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [MULT_W:0]   trial;
  logic              ge;
  logic              last_bit;

  // Restoring division, one quotient bit a cycle. The numerator shifts out
  // at the top while the quotient bits shift in at the bottom.
  always_comb begin
    trial    = {rem_r, q_sr_r[QW-1]};
    ge       = trial >= {1'b0, mult};
    last_bit = busy_r && (cnt_r == CNT_W'(QW - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_bit;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      q_sr_r <= num;
    end else if (busy_r) begin
      rem_r  <= ge ? MULT_W'(trial - {1'b0, mult}) : MULT_W'(trial);
      q_sr_r <= {q_sr_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  // The quotient is at most QW bits wide, so it never reaches the unit limit.
  assign quot = UNITS_W'(q_sr_r);

endmodule

>>> sv/bgsc_smod.sv
`timescale 1ns / 1ps

module bgsc_smod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bgsc_pkg::UNITS_W-1:0]  val,
  input  logic [bgsc_pkg::TICK_W-1:0]   div,
  output logic                          done,
  output logic [bgsc_pkg::TICK_W-1:0]   rem
);
  import bgsc_pkg::*;

  localparam int CNT_W = $clog2(UNITS_W);

  logic [UNITS_W-1:0] v_sr_r;
  logic [TICK_W-1:0]  div_r;
  logic [TICK_W-1:0]  rem_r;
  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [TICK_W:0]    trial;
  logic               ge;
  logic               last_bit;

  // Remainder by Horner's rule, MSB first: r = (2r + bit) mod div.
  always_comb begin
    trial    = {rem_r, v_sr_r[UNITS_W-1]};
    ge       = trial >= {1'b0, div_r};
    last_bit = busy_r && (cnt_r == CNT_W'(UNITS_W - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_bit;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_sr_r <= val;
      div_r  <= div;
      rem_r  <= '0;
    end else if (busy_r) begin
      v_sr_r <= {v_sr_r[UNITS_W-2:0], 1'b0};
      rem_r  <= ge ? TICK_W'(trial - {1'b0, div_r}) : TICK_W'(trial);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> tb/step_tick_checker.sv
`timescale 1ns / 1ps

module step_tick_checker #(
  parameter int CATCHUP = bgsc_pkg::CATCHUP_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [bgsc_pkg::OP_W-1:0]          in_op,
  input  logic signed [bgsc_pkg::BEAT_W-1:0] in_beat_pos,
  input  logic                               in_beat_valid,
  input  logic [bgsc_pkg::SET_W-1:0]         in_set_value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [bgsc_pkg::TICK_W-1:0]        out_tick,
  input  logic                               out_last,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic                               cfg_data,
  output int                                 mismatches,
  output int                                 ticks_pending
);
  import bgsc_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick;
    logic              last;
  } tick_t;

  localparam u64_t UNITS_TOP = (u64_t'(1) << UNITS_W) - 1;

  tick_t ticks_due[$];
  int    errs = 0;

  // Own copy of the block's state and its one register.
  logic                     clk_bound;
  logic                     run;
  logic                     grid_ok;
  logic [MULT_W-1:0]        mult_q;
  logic [TICK_W-1:0]        div_q;
  logic [TICK_W-1:0]        count_q;
  logic [UNITS_W-1:0]       units_q;
  logic signed [BEAT_W-1:0] base_q;

  function automatic void apply_clock_bound(logic bound);
    clk_bound = bound;
    // Rebinding a running counter forces the next valid beat to take the grid.
    if (clk_bound && run) begin
      grid_ok = 1'b0;
      units_q = '0;
    end
  endfunction

  function automatic void predict_ticks(logic [OP_W-1:0] op, logic signed [BEAT_W-1:0] beat,
                                        logic bvalid, logic [SET_W-1:0] value);
    longint            delta;
    u64_t              target;
    u64_t              advance;
    u64_t              at;
    u64_t              steps;
    u64_t              first;
    u64_t              k;
    u64_t              pos_k;
    logic [MULT_W-1:0] nm;
    logic [TICK_W-1:0] nd;
    logic              changed;
    tick_t             t;
    case (op)
      OP_START: begin
        run = 1'b0;
        if (clk_bound) begin
          run     = 1'b1;
          count_q = '0;
          units_q = '0;
          grid_ok = bvalid;
          if (bvalid) base_q = beat;
          t.tick = '0;
          t.last = 1'b1;
          ticks_due.push_back(t);
        end
      end
      OP_STOP: run = 1'b0;
      OP_BEAT: begin
        if (run && clk_bound && bvalid) begin
          if (!grid_ok) begin
            base_q  = beat;
            grid_ok = 1'b1;
            units_q = '0;
          end else begin
            delta  = longint'(beat) - longint'(base_q);
            target = 0;
            if (delta > 0) begin
              target = (u64_t'(delta) * div_q) / (u64_t'(mult_q) << FRAC_SHIFT);
              if (target > UNITS_TOP) target = UNITS_TOP;
            end
            if (target > units_q) begin
              advance = target - units_q;
              at      = (count_q % div_q + advance % div_q) % div_q;
              count_q = at[TICK_W-1:0];
              steps   = (advance > CATCHUP) ? CATCHUP : advance;
              first   = (at + div_q - (steps - 1) % div_q) % div_q;
              units_q = target[UNITS_W-1:0];
              // Only the newest ticks of a long jump come out, ending on the count.
              for (k = 0; k < steps; k++) begin
                pos_k  = (first + k) % div_q;
                t.tick = pos_k[TICK_W-1:0];
                t.last = (k + 1 == steps);
                ticks_due.push_back(t);
              end
            end
          end
        end
      end
      OP_SET_MULT, OP_SET_DIV: begin
        nm = mult_q;
        nd = div_q;
        if (op == OP_SET_MULT) begin
          nm = (value == '0) ? MULT_W'(1) : value;
        end else if (value == '0) begin
          nd = TICK_W'(1);
        end else if (value > DIV_MAX) begin
          nd = DIV_MAX;
        end else begin
          nd = value[TICK_W-1:0];
        end
        changed = (u64_t'(nm) * div_q) != (u64_t'(mult_q) * nd);
        mult_q  = nm;
        div_q   = nd;
        if (run && clk_bound) begin
          if (count_q >= div_q) count_q = count_q % div_q;
          if (changed && bvalid) begin
            base_q  = beat;
            grid_ok = 1'b1;
            units_q = '0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clk_bound = 1'b0;
      run       = 1'b0;
      grid_ok   = 1'b0;
      mult_q    = MULT_RESET;
      div_q     = DIV_RESET;
      count_q   = '0;
      units_q   = '0;
      base_q    = '0;
      ticks_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_clock_bound(cfg_data);
      // Results are checked before the item taken on this edge is predicted,
      // since that item cannot have produced anything yet.
      if (out_valid && !out_stall) begin
        if (ticks_due.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected tick %0d last %0b with nothing predicted", out_tick, out_last);
        end else begin
          if (ticks_due[0].tick !== out_tick || ticks_due[0].last !== out_last) begin
            errs++;
            if (errs <= 10)
              $display("tick mismatch: expected tick %0d last %0b, got tick %0d last %0b",
                       ticks_due[0].tick, ticks_due[0].last, out_tick, out_last);
          end
          void'(ticks_due.pop_front());
        end
      end
      if (in_valid && !in_stall)
        predict_ticks(in_op, in_beat_pos, in_beat_valid, in_set_value);
    end
    mismatches    <= errs;
    ticks_pending <= ticks_due.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bgsc_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam int HOLD_LONG   = 500;
  localparam int SETTLE      = 200;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_ITEMS = 45;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_op;
  logic [BEAT_W-1:0] in_beat_pos;
  logic              in_beat_valid;
  logic [SET_W-1:0]  in_set_value;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TICK_W-1:0] out_tick;
  logic              out_last;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;

  int mismatches;
  int ticks_pending;

  // Stimulus-side view of the grid, used only to size the beat steps.
  logic [BEAT_W-1:0] cursor;
  int                mult_now;
  int                div_now;

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_asks  = 0;

  beat_grid_step_counter_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_beat_pos   (in_beat_pos),
    .in_beat_valid (in_beat_valid),
    .in_set_value  (in_set_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tick      (out_tick),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  step_tick_checker tick_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_beat_pos   (in_beat_pos),
    .in_beat_valid (in_beat_valid),
    .in_set_value  (in_set_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_tick      (out_tick),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .ticks_pending (ticks_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: a random wait after each item when enabled, or a long hold when asked for.
  logic rx_took      = 1'b0;
  int   rx_left      = 0;
  int   rx_hold_left = 0;
  int   hold_seen    = 0;
  int   rx_draw;

  always @(posedge clk) rx_took <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (hold_seen != hold_asks) begin
      hold_seen    <= hold_asks;
      rx_hold_left <= HOLD_LONG;
      out_stall    <= 1'b1;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_stall    <= 1'b1;
    end else if (rx_took) begin
      rx_draw = rx_idle_on ? $urandom_range(0, 8) : 0;
      out_stall <= (rx_draw > 0);
      rx_left   <= (rx_draw > 0) ? rx_draw - 1 : 0;
    end else if (rx_left > 0) begin
      rx_left   <= rx_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  int stuck = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  function automatic logic [BEAT_W-1:0] any_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[BEAT_W-1:0];
  endfunction

  function automatic longint unit_span();
    return (longint'(mult_now) << FRAC_SHIFT) / div_now;
  endfunction

  function automatic void advance_cursor(int n);
    longint step;
    step   = longint'(n) * unit_span();
    cursor = cursor + step[BEAT_W-1:0];
  endfunction

  task automatic offer(logic [OP_W-1:0] op, logic [BEAT_W-1:0] pos, logic bv,
                       logic [SET_W-1:0] sv);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op         <= op;
    in_beat_pos   <= pos;
    in_beat_valid <= bv;
    in_set_value  <= sv;
    in_valid      <= 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
  endtask

  // Waits until every predicted tick is out, then lets a set in flight finish.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ticks_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_clock_bound(logic bound);
    @(negedge clk);
    cfg_data  <= bound;
    cfg_valid <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_item();
    int          pick;
    int unsigned n;
    longint      span;
    longint      step;
    logic [SET_W-1:0] sv;
    logic        bv;
    span = unit_span();
    pick = $urandom_range(0, 99);
    bv   = ($urandom_range(0, 9) != 0);
    if (pick < 7) begin
      if ($urandom_range(0, 7) == 0) cursor = any_beat();
      offer(OP_START, cursor, bv, SET_W'($urandom_range(0, 255)));
    end else if (pick < 11) begin
      offer(OP_STOP, any_beat(), 1'($urandom_range(0, 1)), SET_W'($urandom_range(0, 255)));
    end else if (pick < 70) begin
      n = $urandom_range(0, 99);
      if (n < 65)      step = longint'($urandom_range(0, 3)) * span;
      else if (n < 82) step = longint'($urandom_range(4, 14)) * span;
      else if (n < 92) step = longint'($urandom_range(15, 4000)) * span;
      else             step = -(longint'($urandom_range(1, 20)) * span);
      step = step + longint'($urandom) % span;
      if (bv) cursor = cursor + step[BEAT_W-1:0];
      offer(OP_BEAT, bv ? cursor : any_beat(), bv, SET_W'($urandom_range(0, 255)));
    end else if (pick < 81) begin
      n = $urandom_range(0, 9);
      if (n < 7)       sv = SET_W'($urandom_range(1, 4));
      else if (n == 7) sv = 8'd0;
      else if (n == 8) sv = 8'd255;
      else             sv = SET_W'($urandom_range(0, 255));
      mult_now = (sv == 0) ? 1 : int'(sv);
      offer(OP_SET_MULT, cursor, $urandom_range(0, 2) != 0, sv);
    end else if (pick < 93) begin
      n = $urandom_range(0, 9);
      if (n < 6)       sv = SET_W'($urandom_range(1, 24));
      else if (n == 6) sv = 8'd0;
      else if (n == 7) sv = SET_W'($urandom_range(96, 255));
      else if (n == 8) sv = SET_W'(div_now);
      else             sv = SET_W'($urandom_range(0, 255));
      div_now = (sv == 0) ? 1 : ((sv > DIV_MAX) ? int'(DIV_MAX) : int'(sv));
      offer(OP_SET_DIV, cursor, $urandom_range(0, 2) != 0, sv);
    end else if ($urandom_range(0, 1) == 0) begin
      offer(OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), any_beat(),
            1'($urandom_range(0, 1)), SET_W'($urandom_range(0, 255)));
    end else begin
      // Garbage of any kind; the grid estimate above may drift, which is harmless.
      offer(OP_W'($urandom_range(0, 7)), any_beat(), 1'($urandom_range(0, 1)),
            SET_W'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_op         = OP_START;
    in_beat_pos   = '0;
    in_beat_valid = 1'b0;
    in_set_value  = '0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    cursor        = '0;
    mult_now      = int'(MULT_RESET);
    div_now       = int'(DIV_RESET);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // No clock bound yet: starts and beats do nothing, sets are only stored.
    offer(OP_START, '0, 1'b1, '0);
    offer(OP_BEAT, 48'h0000_0010_0000, 1'b1, '0);
    offer(OP_SET_MULT, '0, 1'b1, 8'd0);
    offer(OP_SET_DIV, '0, 1'b1, 8'd255);
    offer(OP_SET_DIV, '0, 1'b0, 8'd0);
    offer(OP_SPARE_LO, any_beat(), 1'b1, 8'd255);
    offer(OP_SPARE_HI, any_beat(), 1'b0, 8'd0);
    mult_now = 1;
    div_now  = 1;
    drain();
    write_clock_bound(1'b1);

    offer(OP_SET_DIV, '0, 1'b0, 8'd16);
    div_now = 16;
    offer(OP_START, '0, 1'b0, '0);
    cursor = 48'h0000_1234_5678;
    offer(OP_BEAT, cursor, 1'b1, '0);
    advance_cursor(3);
    offer(OP_BEAT, cursor, 1'b1, '0);
    offer(OP_BEAT, cursor - 48'h0000_0001_4000, 1'b1, '0);
    offer(OP_BEAT, cursor + 48'h0000_00A0_0000, 1'b0, '0);
    advance_cursor(100);
    offer(OP_BEAT, cursor, 1'b1, '0);
    offer(OP_SET_DIV, cursor, 1'b1, 8'd16);
    offer(OP_SET_DIV, cursor, 1'b1, 8'd5);
    div_now = 5;
    advance_cursor(7);
    offer(OP_BEAT, cursor, 1'b1, '0);
    offer(OP_SET_MULT, cursor, 1'b0, 8'd3);
    mult_now = 3;
    advance_cursor(2);
    offer(OP_BEAT, cursor, 1'b1, '0);
    offer(OP_STOP, cursor, 1'b1, '0);
    advance_cursor(4);
    offer(OP_BEAT, cursor, 1'b1, '0);
    offer(OP_SET_MULT, cursor, 1'b1, 8'd255);
    offer(OP_SET_DIV, cursor, 1'b1, 8'd0);
    mult_now = 255;
    div_now  = 1;
    // Extremes of the beat range: a start at the top, then the whole range in one step.
    offer(OP_START, 48'h7FFF_FFFF_FFFF, 1'b1, '0);
    offer(OP_BEAT, 48'h8000_0000_0000, 1'b1, '0);
    offer(OP_SET_MULT, 48'h8000_0000_0000, 1'b1, 8'd1);
    offer(OP_SET_DIV, 48'h8000_0000_0000, 1'b1, 8'd96);
    mult_now = 1;
    div_now  = 96;
    offer(OP_BEAT, 48'h7FFF_FFFF_FFFF, 1'b1, '0);
    cursor = '0;
    offer(OP_START, cursor, 1'b1, '0);

    for (int ph = 0; ph < 7; ph++) begin
      // Writing a bound clock here while the counter runs clears its grid.
      drain();
      write_clock_bound(ph != 2);
      tx_idle_on = (ph != 3);
      rx_idle_on = (ph != 3);
      if (ph == 4) begin
        tx_idle_on = 1'b0;
        hold_asks++;
      end
      offer(OP_START, cursor, 1'b1, '0);
      for (int i = 1; i < ((ph == 2) ? 12 : PHASE_ITEMS); i++) begin
        if (ph == 4 && i == 30) tx_idle_on = 1'b1;
        if (ph == 5 && i == 24) drain();
        random_item();
      end
    end

    drain();
    if (mismatches == 0 && ticks_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/bgsc_pkg.sv
sv/bgsc_smul.sv
sv/bgsc_sdiv.sv
sv/bgsc_smod.sv
sv/beat_grid_step_counter_unit.sv
tb/step_tick_checker.sv
tb/testbench.sv
